@@ src/cld_pkg.sv @@
// ----------------------------------------------------------------------------
// cld_pkg - shared types and constants of the categorical label draw
// Request and response word layouts, operation codes, table sizing defaults.
// ----------------------------------------------------------------------------
package cld_pkg;

   localparam int RowsDefault          = 256;
   localparam int SitesDefault         = 256;
   localparam int MaxComponentsDefault = 8;

   // operation codes
   localparam logic [1:0] OpLoadWeight = 2'd0;
   localparam logic [1:0] OpLoadLabel  = 2'd1;
   localparam logic [1:0] OpDraw       = 2'd2;

   // register indexes
   localparam logic [0:0] CsrComponents = 1'd0;
   localparam logic [0:0] CsrLevels     = 1'd1;

   localparam logic [3:0] ComponentsReset = 4'd8;
   localparam logic [7:0] LevelsReset     = 8'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  row_index;
      logic [7:0]  site_index;
      logic [2:0]  component;
      logic [15:0] load_value;
      logic [7:0]  observed_level;
      logic [15:0] uniform_draw;
   } req_word_type;

   typedef struct packed {
      logic [3:0] drawn_component;
      logic       draw_made;
   } rsp_word_type;

   // controller -> datapath commands
   typedef struct packed {
      logic capture;    // latch request word
      logic write_load; // perform a table load
      logic read_issue; // issue table reads for component
      logic accumulate; // add read data into total
      logic div_start;  // start last-weight division
      logic div_step;   // one restoring division step
      logic mul_step;   // form threshold
      logic scan_step;  // compare running sum for component
      logic [3:0] comp; // component being addressed
   } cmd_type;

   typedef struct packed {
      logic       is_load;
      logic       is_draw;
      logic       in_range;
      logic       hit;
      logic [3:0] last_comp;
   } sts_type;

endpackage

@@ src/categorical_label_draw.sv @@
// ----------------------------------------------------------------------------
// categorical_label_draw - inverse-CDF categorical draw over stored weights
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// A load word passes through a decode state that writes its table. A draw
// steps through decode, table reads (one weight and one label per cycle from
// single-port memories), a bit-serial restoring divider for the last weight
// over the levels register, a multiply, the threshold scan and an emit state
// that fills the response register; no new word is taken before that draw
// has answered. An out-of-range draw goes from decode straight to emit. No
// input is taken until the response register is free. Memories hold no reset
// value.
module categorical_label_draw import cld_pkg::*; #(
   parameter int ROWS           = RowsDefault,
   parameter int SITES          = SitesDefault,
   parameter int MAX_COMPONENTS = MaxComponentsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_data
);
   logic [3:0] comp_cfg_ff;
   logic [7:0] level_cfg_ff;
   cmd_type    cmd;
   sts_type    sts;
   logic [3:0] hit_comp;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         comp_cfg_ff  <= ComponentsReset;
         level_cfg_ff <= LevelsReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrComponents: comp_cfg_ff  <= csr_data[3:0];
            CsrLevels:     level_cfg_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   cld_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .rsp_word, .sts, .hit_comp, .cmd
   );

   cld_datapath #(
      .ROWS(ROWS), .SITES(SITES), .MAX_COMPONENTS(MAX_COMPONENTS)
   ) u_datapath (
      .clock, .req_word, .cmd, .comp_cfg(comp_cfg_ff),
      .level_cfg(level_cfg_ff), .sts, .hit_comp
   );

   // a response word always names a component exactly when a draw was made
   a_made_comp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.draw_made == (rsp_word.drawn_component != 4'd0)))
      else $error("draw flag and component disagree");

   // no new word is taken while a response is pending
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("accept during pending response");

   // capture only happens from idle
   a_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> req_stall)
      else $error("controller did not leave idle after capture");

endmodule

@@ src/cld_datapath.sv @@
// ----------------------------------------------------------------------------
// cld_datapath - tables, accumulator, divider and threshold scan
// Holds weight and label memories and performs one step per command.
// ----------------------------------------------------------------------------
module cld_datapath import cld_pkg::*; #(
   parameter int ROWS           = RowsDefault,
   parameter int SITES          = SitesDefault,
   parameter int MAX_COMPONENTS = MaxComponentsDefault
) (
   input  logic         clock,
   input  req_word_type req_word,
   input  cmd_type      cmd,
   input  logic [3:0]   comp_cfg,
   input  logic [7:0]   level_cfg,
   output sts_type      sts,
   output logic [3:0]   hit_comp
);
   localparam int LabelsPer = MAX_COMPONENTS - 1;
   localparam int WDepth    = ROWS * MAX_COMPONENTS;
   localparam int LDepth    = SITES * LabelsPer;
   localparam int WAw       = $clog2(WDepth);
   localparam int LAw       = $clog2(LDepth);
   localparam int TotW      = 16 + 5;

   logic [15:0] weight_mem [WDepth];
   logic [7:0]  label_mem  [LDepth];

   req_word_type word_ff;
   logic [15:0]  wrd_ff;
   logic [7:0]   lrd_ff;
   logic [TotW-1:0] total_ff;
   logic [15:0]  last_w_ff;
   logic [15:0]  quo_ff;
   logic [8:0]   rem_ff;
   logic [7:0]   div_ff;
   logic [TotW+15:0] thresh_ff;
   logic [TotW-1:0]  acc_ff;
   logic [15:0]  prob_ff [MAX_COMPONENTS];
   logic         hit_ff;
   logic [3:0]   hit_comp_ff;
   logic [3:0]   q_ff;

   // clamp component count
   logic [3:0] q_c;
   always_comb begin
      if (comp_cfg < 4'd2)
         q_c = 4'd2;
      else if (32'(comp_cfg) > MAX_COMPONENTS)
         q_c = 4'(MAX_COMPONENTS);
      else
         q_c = comp_cfg;
   end

   // addresses: loads use the captured component, reads the commanded one
   logic [WAw:0] w_addr;
   logic [LAw:0] l_addr;
   logic [3:0]   acomp;
   always_comb begin
      acomp  = cmd.write_load ? 4'(word_ff.component) : cmd.comp;
      w_addr = (WAw+1)'(32'(word_ff.row_index) * MAX_COMPONENTS + 32'(acomp));
      l_addr = (LAw+1)'(32'(word_ff.site_index) * LabelsPer + 32'(acomp));
   end

   // read data lands in the cycle after its issue, so it belongs to comp-1
   logic [3:0] acc_comp;
   always_comb acc_comp = cmd.comp - 4'd1;

   // memories: loads write from the captured word, draws read
   always_ff @(posedge clock) begin
      if (cmd.write_load) begin
         if (word_ff.operation == OpLoadWeight &&
             32'(word_ff.row_index) < ROWS &&
             32'(word_ff.component) < MAX_COMPONENTS)
            weight_mem[w_addr[WAw-1:0]] <= word_ff.load_value;
         if (word_ff.operation == OpLoadLabel &&
             32'(word_ff.site_index) < SITES &&
             32'(word_ff.component) < LabelsPer)
            label_mem[l_addr[LAw-1:0]] <= word_ff.load_value[7:0];
      end
      if (cmd.read_issue) begin
         wrd_ff <= weight_mem[w_addr[WAw-1:0]];
         lrd_ff <= label_mem[l_addr[LAw-1:0]];
      end
   end

   // datapath registers
   logic [8:0] rem_sh;
   always_comb rem_sh = {rem_ff[7:0], last_w_ff[15]};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         word_ff  <= req_word;
         total_ff <= '0;
         acc_ff   <= '0;
         hit_ff   <= 1'b0;
         hit_comp_ff <= '0;
         q_ff     <= q_c;
         div_ff   <= (level_cfg == 8'd0) ? 8'd1 : level_cfg;
      end
      // masked weights into the probability registers, the last weight unmasked
      if (cmd.accumulate) begin
         if (acc_comp == q_ff - 4'd1) begin
            prob_ff[acc_comp[$clog2(MAX_COMPONENTS)-1:0]] <= wrd_ff;
            last_w_ff <= wrd_ff;
         end else if (lrd_ff == word_ff.observed_level) begin
            prob_ff[acc_comp[$clog2(MAX_COMPONENTS)-1:0]] <= wrd_ff;
            total_ff <= total_ff + TotW'(wrd_ff);
         end else begin
            prob_ff[acc_comp[$clog2(MAX_COMPONENTS)-1:0]] <= '0;
         end
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= '0;
      end
      // restoring division, one quotient bit per step
      if (cmd.div_step) begin
         last_w_ff <= {last_w_ff[14:0], 1'b0};
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_ff <= 9'(rem_sh - {1'b0, div_ff});
            quo_ff <= {quo_ff[14:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[14:0], 1'b0};
         end
      end
      if (cmd.mul_step)
         thresh_ff <= (TotW+16)'(word_ff.uniform_draw)
                      * (TotW+16)'(total_ff + TotW'(quo_ff));
      // scan running sum
      if (cmd.scan_step && !hit_ff) begin
         acc_ff <= acc_ff + TotW'(prob_ff[cmd.comp[$clog2(MAX_COMPONENTS)-1:0]]);
         if ({acc_ff + TotW'(prob_ff[cmd.comp[$clog2(MAX_COMPONENTS)-1:0]]), 16'd0}
             > thresh_ff) begin
            hit_ff      <= 1'b1;
            hit_comp_ff <= cmd.comp + 4'd1;
         end
      end
   end

   // status back to the controller
   always_comb begin
      sts.is_load   = word_ff.operation == OpLoadWeight ||
                      word_ff.operation == OpLoadLabel;
      sts.is_draw   = word_ff.operation == OpDraw;
      sts.in_range  = 32'(word_ff.row_index) < ROWS && 32'(word_ff.site_index) < SITES;
      sts.hit       = hit_ff;
      sts.last_comp = q_ff - 4'd1;
   end
   assign hit_comp = hit_comp_ff;

endmodule

@@ src/cld_control.sv @@
// ----------------------------------------------------------------------------
// cld_control - sequencer for loads and draws
// Steps reads, division, threshold and scan; holds the response register.
// ----------------------------------------------------------------------------
module cld_control import cld_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  sts_type      sts,
   input  logic [3:0]   hit_comp,
   output cmd_type      cmd
);
   typedef enum logic [2:0] {
      IDLE, DECODE, READ, DIVIDE, MULT, SCAN, EMIT
   } state_type;

   state_type    state_ff;
   logic [3:0]   cnt_ff;
   logic         rvalid_ff;
   rsp_word_type rword_ff;

   // a pending response holds off the next word
   assign req_stall = state_ff != IDLE || rvalid_ff;
   assign rsp_valid = rvalid_ff;
   assign rsp_word  = rword_ff;

   // command decode
   always_comb begin
      cmd            = '0;
      cmd.comp       = cnt_ff;
      cmd.capture    = state_ff == IDLE && req_valid && !rvalid_ff;
      cmd.write_load = state_ff == DECODE && sts.is_load;
      unique case (state_ff)
         READ: begin
            cmd.read_issue = cnt_ff <= sts.last_comp;
            cmd.accumulate = cnt_ff != 4'd0;
            cmd.div_start  = cnt_ff == sts.last_comp + 4'd1;
         end
         DIVIDE:  cmd.div_step  = 1'b1;
         MULT:    cmd.mul_step  = 1'b1;
         SCAN:    cmd.scan_step = 1'b1;
         default: ;
      endcase
   end

   // state machine and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         cnt_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (rvalid_ff) begin
                  if (!rsp_stall) rvalid_ff <= 1'b0;
               end else if (req_valid)
                  state_ff <= DECODE;
            end
            DECODE: begin
               cnt_ff <= '0;
               if (sts.is_draw && sts.in_range)
                  state_ff <= READ;
               else if (sts.is_draw)
                  state_ff <= EMIT;
               else
                  state_ff <= IDLE;
            end
            READ: begin
               if (cnt_ff == sts.last_comp + 4'd1) begin
                  cnt_ff   <= '0;
                  state_ff <= DIVIDE;
               end else
                  cnt_ff <= cnt_ff + 4'd1;
            end
            DIVIDE: begin
               if (cnt_ff == 4'd15) state_ff <= MULT;
               cnt_ff <= cnt_ff + 4'd1;
            end
            MULT: begin
               cnt_ff   <= '0;
               state_ff <= SCAN;
            end
            SCAN: begin
               if (cnt_ff == sts.last_comp) state_ff <= EMIT;
               cnt_ff <= cnt_ff + 4'd1;
            end
            EMIT: begin
               // hit flag was cleared at capture, so an out-of-range draw gives zero
               rword_ff.drawn_component <= sts.hit ? hit_comp : 4'd0;
               rword_ff.draw_made       <= sts.hit;
               rvalid_ff <= 1'b1;
               state_ff  <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

@@ sim/categorical_label_draw_checker.sv @@
// ----------------------------------------------------------------------------
// categorical_label_draw_checker - response checker of the categorical draw
// Watches the request, response and register ports. It keeps its own copy of
// both tables and both registers, and predicts the response of every
// accepted draw. Each response is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module categorical_label_draw_checker import cld_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_data,
   output int           mismatches,
   output int           draws_pending
);

   localparam int Comps  = MaxComponentsDefault;
   localparam int Labels = MaxComponentsDefault - 1;

   logic [15:0]  weight_copy [RowsDefault*Comps];
   logic [7:0]   label_copy  [SitesDefault*Labels];
   logic [3:0]   comps_reg;
   logic [7:0]   levels_reg;
   rsp_word_type draw_results [$];

   initial mismatches = 0;
   assign draws_pending = draw_results.size();

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // inverse-CDF pick over the masked weights of one row and site
   function automatic rsp_word_type pick_component(input req_word_type w);
      int unsigned q;
      int unsigned k;
      logic [63:0] probs [Comps];
      logic [63:0] total;
      logic [63:0] thresh;
      logic [63:0] acc;
      rsp_word_type r;
      q = comps_reg;
      k = (levels_reg == 0) ? 1 : levels_reg;
      total = 0;
      acc = 0;
      r = '0;
      if (q < 2) q = 2;
      if (q > Comps) q = Comps;
      for (int l = 0; l < q - 1; l++) begin
         probs[l] = (label_copy[w.site_index*Labels + l] == w.observed_level) ?
                    64'(weight_copy[w.row_index*Comps + l]) : 64'd0;
         total += probs[l];
      end
      probs[q-1] = 64'(weight_copy[w.row_index*Comps + q - 1]);
      total += probs[q-1] / k;
      thresh = 64'(w.uniform_draw) * total;
      for (int l = 0; l < q; l++) begin
         acc += probs[l];
         if ((acc << 16) > thresh) begin
            r.drawn_component = 4'(l + 1);
            r.draw_made = 1'b1;
            return r;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         comps_reg  <= ComponentsReset;
         levels_reg <= LevelsReset;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == CsrComponents) comps_reg <= csr_data[3:0];
            else levels_reg <= csr_data[7:0];
         end
         // accepted request words
         if (req_valid && !req_stall) begin
            case (req_word.operation)
               OpLoadWeight: weight_copy[req_word.row_index*Comps + req_word.component]
                                = req_word.load_value;
               OpLoadLabel: if (req_word.component < Labels)
                  label_copy[req_word.site_index*Labels + req_word.component]
                     = req_word.load_value[7:0];
               OpDraw: draw_results.push_back(pick_component(req_word));
               default: ;
            endcase
         end
         // accepted response words
         if (rsp_valid && !rsp_stall) begin
            if (draw_results.size() == 0) begin
               report("response word with no draw outstanding");
            end else begin
               rsp_word_type e;
               e = draw_results.pop_front();
               if (rsp_word.drawn_component !== e.drawn_component)
                  report($sformatf("drawn_component %0d, predicted %0d",
                                   rsp_word.drawn_component, e.drawn_component));
               if (rsp_word.draw_made !== e.draw_made)
                  report($sformatf("draw_made %0b, predicted %0b",
                                   rsp_word.draw_made, e.draw_made));
            end
         end
      end
   end

endmodule

@@ sim/categorical_label_draw_tb.sv @@
// ----------------------------------------------------------------------------
// categorical_label_draw_tb - regression bench of the categorical draw
// Fills a pool of rows and sites, runs directed draws on the corner cases and
// then random load and draw words under several register settings and
// several idle patterns. The checker predicts and compares; this module only
// makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module categorical_label_draw_tb;
   import cld_pkg::*;

   localparam logic [1:0] OpUnused  = 2'd3;
   localparam int         StallLimit = 5000;
   localparam int         DrainWait  = 60;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [0:0]   csr_index = CsrComponents;
   logic [15:0]  csr_data = '0;
   int           mismatches;
   int           draws_pending;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           quiet_cycles = 0;

   // rows and sites that are fully written before any draw reads them
   logic [7:0] row_pool  [8] = '{8'd0, 8'd255, 8'd85, 8'd170, 8'd15, 8'd240, 8'd51, 8'd204};
   logic [7:0] site_pool [8] = '{8'd0, 8'd255, 8'd85, 8'd170, 8'd15, 8'd240, 8'd51, 8'd204};
   logic [7:0] level_pool [4] = '{8'd0, 8'd1, 8'd2, 8'd255};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   categorical_label_draw uut (
      .clock, .reset, .req_valid, .req_stall, .req_word, .rsp_valid, .rsp_stall,
      .rsp_word, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   categorical_label_draw_checker checker_inst (
      .clock, .reset, .req_valid, .req_stall, .req_word, .rsp_valid, .rsp_stall,
      .rsp_word, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .mismatches, .draws_pending
   );

   // receiver back-pressure
   always @(posedge clock)
      rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

   // watchdog on cycles where no word moves on any port
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_word(input req_word_type w);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // drop valid, let every draw come back, then let any load finish
   task automatic settle;
      req_valid <= 1'b0;
      @(posedge clock);
      while (draws_pending != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   function automatic req_word_type noise_word(input logic [1:0] op);
      req_word_type w;
      logic [63:0]  bits;
      bits = {$urandom, $urandom};
      w = bits[$bits(req_word_type)-1:0];
      w.operation = op;
      return w;
   endfunction

   function automatic logic [15:0] weight_value;
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_word_type weight_word(input logic [7:0] row, input logic [2:0] c,
                                                input logic [15:0] v);
      req_word_type w;
      w = noise_word(OpLoadWeight);
      w.row_index = row;
      w.component = c;
      w.load_value = v;
      return w;
   endfunction

   function automatic req_word_type label_word(input logic [7:0] site, input logic [2:0] c,
                                               input logic [7:0] lvl);
      req_word_type w;
      w = noise_word(OpLoadLabel);
      w.site_index = site;
      w.component = c;
      w.load_value[7:0] = lvl;
      return w;
   endfunction

   function automatic req_word_type draw_word(input logic [7:0] row, input logic [7:0] site,
                                              input logic [7:0] lvl, input logic [15:0] u);
      req_word_type w;
      w = noise_word(OpDraw);
      w.row_index = row;
      w.site_index = site;
      w.observed_level = lvl;
      w.uniform_draw = u;
      return w;
   endfunction

   function automatic req_word_type random_word;
      int unsigned pick;
      logic [7:0] lvl;
      pick = $urandom_range(99);
      lvl = ($urandom_range(3) == 0) ? 8'($urandom) : level_pool[$urandom_range(3)];
      if (pick < 55)
         return draw_word(row_pool[$urandom_range(7)], site_pool[$urandom_range(7)], lvl,
                          ($urandom_range(9) == 0) ? weight_value() : 16'($urandom));
      if (pick < 82)
         return weight_word(($urandom_range(4) == 0) ? 8'($urandom) : row_pool[$urandom_range(7)],
                            3'($urandom), weight_value());
      if (pick < 97)
         return label_word(($urandom_range(4) == 0) ? 8'($urandom)
                           : site_pool[$urandom_range(7)], 3'($urandom), lvl);
      return noise_word(OpUnused);
   endfunction

   initial begin
      logic [3:0]  comps_set  [9] = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd5, 4'd3, 4'd8, 4'd7, 4'd1};
      logic [7:0]  levels_set [9] = '{8'd2, 8'd1, 8'd255, 8'd0, 8'd3, 8'd255, 8'd1, 8'd4, 8'd2};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the draw pool with reset register values
      foreach (row_pool[i])
         for (int c = 0; c < 8; c++) send_word(weight_word(row_pool[i], 3'(c), weight_value()));
      foreach (site_pool[i])
         for (int c = 0; c < 7; c++)
            send_word(label_word(site_pool[i], 3'(c), level_pool[$urandom_range(3)]));

      // directed: all-zero row gives no draw, then extremes of uniform and levels
      for (int c = 0; c < 8; c++) send_word(weight_word(8'd0, 3'(c), 16'h0000));
      send_word(draw_word(8'd0, 8'd0, 8'd0, 16'h8000));
      send_word(weight_word(8'd0, 3'd7, 16'hffff));
      send_word(label_word(8'd0, 3'd7, 8'd9));       // out of range label slot, ignored
      send_word(label_word(8'd0, 3'd0, 8'd255));
      send_word(weight_word(8'd0, 3'd0, 16'hffff));
      send_word(draw_word(8'd0, 8'd0, 8'd255, 16'h0000));
      send_word(draw_word(8'd0, 8'd0, 8'd255, 16'hffff));
      send_word(draw_word(8'd0, 8'd0, 8'd7, 16'hffff));
      send_word(draw_word(8'd255, 8'd255, 8'd0, 16'h0001));
      send_word(noise_word(OpUnused));
      send_word(draw_word(8'd255, 8'd255, 8'd255, 16'hfffe));

      // random phases: receiver idles more, then sender idles more, then neither idles
      for (int p = 0; p < 9; p++) begin
         settle();
         write_reg(CsrComponents, {12'($urandom_range(4095)), comps_set[p]});
         write_reg(CsrLevels, {8'($urandom), levels_set[p]});
         send_idle_pct = (p < 3) ? 34 : (p < 6) ? 54 : 0;
         recv_idle_pct = (p < 3) ? 54 : (p < 6) ? 34 : 0;
         for (int n = 0; n < 140; n++) send_word(random_word());
      end

      settle();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
